>>> design/sbm_pkg.sv
// shared types and fixed constants of the spectral band meter
package sbm_pkg;

  localparam int MAG_W     = 32;
  localparam int DB_W      = 16;
  localparam int LEVEL_W   = 16;
  localparam int BAND_W    = 8;
  localparam int CFG_W     = 16;
  localparam int RATIO_W   = 14;
  localparam int SLOPE_W   = 16;
  localparam int REG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_RATIO     = 1'b1;

  // reset values
  localparam int THRESHOLD_RESET = -5120;
  localparam int RATIO_RESET     = 1024;
  localparam int RATIO_MIN       = 256;
  localparam int SLOPE_RESET     = 65536 - (2**24) / RATIO_RESET;

  // level arithmetic
  localparam int DB_PER_LOG2_Q16 = 394566;
  localparam int FLOOR_DB_Q8     = -30720;
  localparam int RANGE_IN_Q8     = 23040;
  localparam int RANGE_RED_Q8    = 6144;
  localparam int RELEASE_STEP    = 65536 - 57672;

  // range_in = 2^9 * 45, the /45 by reciprocal
  localparam int IN_PRE_SHIFT  = 9;
  localparam int IN_DIV        = 45;
  localparam int IN_MUL_SHIFT  = 29;
  localparam int IN_MUL        = ((2**IN_MUL_SHIFT) + IN_DIV - 1) / IN_DIV;

  // range_red = 2^11 * 3, the /3 by reciprocal
  localparam int RED_PRE_SHIFT = 11;
  localparam int RED_DIV       = 3;
  localparam int RED_MUL_SHIFT = 20;
  localparam int RED_MUL       = ((2**RED_MUL_SHIFT) + RED_DIV - 1) / RED_DIV;

  // sideband that travels with each bin through the level pipeline
  typedef struct packed {
    logic              close;
    logic              last;
    logic [BAND_W-1:0] band;
  } sbm_tag_t;

endpackage

>>> design/sbm_slope_div.sv
// bit-serial divider that turns a ratio write into the reduction slope
module sbm_slope_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sbm_pkg::RATIO_W-1:0]  divisor,
  output logic                         busy,
  output logic [sbm_pkg::SLOPE_W-1:0]  slope
);

  localparam int STEPS = 25;  // dividend is 2^24

  logic [sbm_pkg::RATIO_W-1:0] dvs;
  logic [14:0]                 rem;
  logic [14:0]                 rem_sh;
  logic [14:0]                 rem_next;
  logic [16:0]                 quo;
  logic [16:0]                 quo_next;
  logic [4:0]                  cnt;
  logic                        qbit;

  always_comb begin
    rem_sh   = {rem[13:0], (cnt == 5'(STEPS - 1))};
    qbit     = (rem_sh >= {1'b0, dvs});
    rem_next = qbit ? (rem_sh - {1'b0, dvs}) : rem_sh;
    quo_next = {quo[15:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      slope <= sbm_pkg::SLOPE_W'(sbm_pkg::SLOPE_RESET);
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        busy  <= 1'b0;
        slope <= sbm_pkg::SLOPE_W'(17'h1_0000 - quo_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

endmodule

>>> design/sbm_log_pipe.sv
// pipelined log2 by repeated squaring, scaled to db in q7.8
module sbm_log_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [sbm_pkg::MAG_W-1:0]         in_mag,
  input  sbm_pkg::sbm_tag_t                 in_tag,
  output logic                              out_valid,
  output logic signed [sbm_pkg::DB_W-1:0]   out_db,
  output sbm_pkg::sbm_tag_t                 out_tag
);

  localparam int SQ_STAGES = 16;

  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [4:0]        msb;
    sbm_pkg::sbm_tag_t tag;
  } side_t;

  // input stage
  logic                      v1;
  logic [sbm_pkg::MAG_W-1:0] mag1;
  sbm_pkg::sbm_tag_t         tag1;

  // leading one stage
  side_t                     sd2;
  logic [sbm_pkg::MAG_W-1:0] mag2;
  logic [4:0]                msb_enc;

  // squaring chain, index 0 holds the normalised mantissa
  side_t       sd_q [0:SQ_STAGES];
  logic [30:0] y_q  [0:SQ_STAGES];
  logic [15:0] fr_q [0:SQ_STAGES];
  logic [61:0] sq   [0:SQ_STAGES-1];
  logic [30:0] y_norm;
  logic [31:0] y_shift;

  // scaling stage
  side_t              sd_d;
  logic signed [41:0] prod_d;
  logic signed [21:0] log2_q16;

  always_comb begin
    msb_enc = '0;
    for (int i = 0; i < sbm_pkg::MAG_W; i++) begin
      if (mag1[i]) msb_enc = 5'(i);
    end
  end

  always_comb begin
    y_shift = mag2 << (5'd30 - sd2.msb);
    if (sd2.msb <= 5'd30) begin
      y_norm = y_shift[30:0];
    end else begin
      y_norm = mag2[31:1];
    end
  end

  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      sq[k] = 62'(y_q[k]) * 62'(y_q[k]);
    end
  end

  // integer part is msb - 16, fraction from the chain
  assign log2_q16 = $signed({6'(sd_q[SQ_STAGES].msb) - 6'd16, fr_q[SQ_STAGES]});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      sd2  <= '0;
      sd_d <= '0;
      for (int k = 0; k <= SQ_STAGES; k++) begin
        sd_q[k] <= '0;
      end
    end else if (en) begin
      v1        <= in_valid;
      sd2.valid <= v1;
      sd2.zero  <= (mag1 == '0);
      sd2.msb   <= msb_enc;
      sd2.tag   <= tag1;
      sd_q[0]   <= sd2;
      for (int k = 0; k < SQ_STAGES; k++) begin
        sd_q[k+1] <= sd_q[k];
      end
      sd_d <= sd_q[SQ_STAGES];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      mag1    <= in_mag;
      tag1    <= in_tag;
      mag2    <= mag1;
      y_q[0]  <= y_norm;
      fr_q[0] <= '0;
      for (int k = 0; k < SQ_STAGES; k++) begin
        if (sq[k][61]) begin
          y_q[k+1]  <= sq[k][61:31];
          fr_q[k+1] <= fr_q[k] | (16'h8000 >> k);
        end else begin
          y_q[k+1]  <= sq[k][60:30];
          fr_q[k+1] <= fr_q[k];
        end
      end
      prod_d <= 42'(log2_q16) * 42'(sbm_pkg::DB_PER_LOG2_Q16);
    end
  end

  assign out_valid = sd_d.valid;
  assign out_tag   = sd_d.tag;
  assign out_db    = sd_d.zero ? sbm_pkg::DB_W'(sbm_pkg::FLOOR_DB_Q8) : $signed(prod_d[39:24]);

endmodule

>>> design/spectral_band_meter_peak_release_top.sv
// top level of the spectral band meter with peak hold and release
//
// s_t* takes one fft bin magnitude per beat (q16.16), bins 0..HALF_BINS of a
// frame in ascending order, back to back, up to one beat per cycle
// m_t* gives one beat per display band once its last bin is in: band index,
// held input level and held gain reduction; tlast marks the final band
// from the beat that closes a band to its result on m_tdata, the path runs
// through the log pipeline (16 squaring stages), the level and reduction
// scaling and the held store read, and then the output register
// throughput is one bin per cycle while s_tready is high, set by the pipeline
// and the held store, which is read and written once per band
// a ratio write starts a bit-serial slope division, s_tready is low until
// it finishes; a threshold write takes effect at once
// when the receiver stalls, one result waits in the output register and a
// second in a skid register, then the whole pipeline holds and s_tready drops
// reset clears counters, band maxima and the per-band valid flags of the held
// store, so every held level reads as zero with no clearing pass
// the held store is read one stage before its write; a band is revisited
// only after every other band, so no forwarding is needed
module spectral_band_meter_peak_release_top #(
  parameter int DISPLAY_BINS = 256,
  parameter int HALF_BINS    = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,   // magnitude[31:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [39:0]                      m_tdata,   // band_index[7:0], input_level[23:8],
                                                      // reduction_level[39:24]
  output logic                             m_tlast,   // frame_last
  input  logic                             cfg_we,
  input  logic [sbm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [sbm_pkg::CFG_W-1:0]        cfg_data
);

  localparam int BAND_AW = $clog2(DISPLAY_BINS);
  localparam int CNT_W   = $clog2(HALF_BINS + 2);
  localparam int REM_W   = BAND_AW + 1;
  localparam int END_Q0  = (HALF_BINS + 1) / DISPLAY_BINS;
  localparam int END_R0  = (HALF_BINS + 1) % DISPLAY_BINS;

  typedef struct packed {
    logic [sbm_pkg::BAND_W-1:0]  band;
    logic [sbm_pkg::LEVEL_W-1:0] in_level;
    logic [sbm_pkg::LEVEL_W-1:0] red_level;
    logic                        last;
  } result_t;

  // held levels: input in the upper half, reduction in the lower half
  function automatic logic [15:0] release_level(input logic [15:0] prev,
                                                input logic [15:0] cur);
    logic [15:0] diff;
    logic [32:0] acc;
    logic [16:0] v;
    diff = prev - cur;
    acc  = {1'b0, prev, 16'h8000} - 33'(diff) * 33'(sbm_pkg::RELEASE_STEP);
    v    = acc[32:16];
    if (cur > prev) begin
      return cur;
    end else if (v[16]) begin
      return 16'hFFFF;
    end
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [15:0]                threshold;
  logic                              div_start;
  logic [sbm_pkg::RATIO_W-1:0]       ratio_in;
  logic [sbm_pkg::RATIO_W-1:0]       div_divisor;
  logic                              div_busy;
  logic [sbm_pkg::SLOPE_W-1:0]       slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'(sbm_pkg::THRESHOLD_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        sbm_pkg::REG_THRESHOLD: threshold <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    div_start = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        sbm_pkg::REG_RATIO: div_start = 1'b1;
        default:            div_start = 1'b0;
      endcase
    end
  end

  // a ratio under 1.0 acts as 1.0
  assign ratio_in    = cfg_data[sbm_pkg::RATIO_W-1:0];
  assign div_divisor = (ratio_in < sbm_pkg::RATIO_W'(sbm_pkg::RATIO_MIN)) ?
                       sbm_pkg::RATIO_W'(sbm_pkg::RATIO_MIN) : ratio_in;

  sbm_slope_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (div_divisor),
    .busy    (div_busy),
    .slope   (slope)
  );

  // ------------------------------------------------------- flow control
  logic    en;          // whole pipeline advances
  logic    accept;
  logic    skid_valid;
  result_t skid;
  logic    out_valid;
  result_t out_res;

  assign en       = !skid_valid;
  assign s_tready = en && !div_busy;
  assign accept   = s_tvalid && s_tready;

  // ----------------------------------------------- bin and band counting
  // band end kept as quotient and remainder of (band+1)*(HALF_BINS+1)/DISPLAY_BINS
  logic [CNT_W-1:0]   bin_cnt;
  logic [BAND_AW-1:0] band_cnt;
  logic [CNT_W-1:0]   end_q;
  logic [REM_W-1:0]   end_r;
  logic [REM_W-1:0]   end_r_sum;
  logic               close_bin;
  logic               last_band;
  sbm_pkg::sbm_tag_t  in_tag;

  assign close_bin = (bin_cnt + CNT_W'(1)) >= end_q;
  assign last_band = (band_cnt == BAND_AW'(DISPLAY_BINS - 1));
  assign end_r_sum = end_r + REM_W'(END_R0);

  always_comb begin
    in_tag.close = close_bin;
    in_tag.last  = last_band;
    in_tag.band  = sbm_pkg::BAND_W'(band_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_cnt  <= '0;
      band_cnt <= '0;
      end_q    <= CNT_W'(END_Q0);
      end_r    <= REM_W'(END_R0);
    end else if (accept) begin
      if (close_bin && last_band) begin
        bin_cnt  <= '0;
        band_cnt <= '0;
        end_q    <= CNT_W'(END_Q0);
        end_r    <= REM_W'(END_R0);
      end else if (close_bin) begin
        bin_cnt  <= bin_cnt + CNT_W'(1);
        band_cnt <= band_cnt + BAND_AW'(1);
        if (end_r_sum >= REM_W'(DISPLAY_BINS)) begin
          end_r <= end_r_sum - REM_W'(DISPLAY_BINS);
          end_q <= end_q + CNT_W'(END_Q0 + 1);
        end else begin
          end_r <= end_r_sum;
          end_q <= end_q + CNT_W'(END_Q0);
        end
      end else begin
        bin_cnt <= bin_cnt + CNT_W'(1);
      end
    end
  end

  // ------------------------------------------------------- level in db
  logic                     log_valid;
  logic signed [15:0]       log_db;
  sbm_pkg::sbm_tag_t        log_tag;

  sbm_log_pipe u_log (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (accept),
    .in_mag    (s_tdata),
    .in_tag    (in_tag),
    .out_valid (log_valid),
    .out_db    (log_db),
    .out_tag   (log_tag)
  );

  // ------------------------------------------ stage 1: offsets and clamps
  logic signed [17:0] t_in;
  logic [14:0]        t_val;
  logic [30:0]        x_in_full;
  logic signed [16:0] over_s;

  logic               v1;
  sbm_pkg::sbm_tag_t  tag1;
  logic [21:0]        x1;
  logic               lin_zero1;
  logic               lin_sat1;
  logic [15:0]        over1;

  always_comb begin
    t_in      = 18'(log_db) + 18'(sbm_pkg::RANGE_IN_Q8);
    t_val     = t_in[14:0];
    x_in_full = {t_val, 16'h0000} - {16'h0000, t_val};  // t * 65535
    over_s    = 17'(log_db) - 17'(threshold);
  end

  // ----------------------------------------- stage 2: the two multiplies
  logic               v2;
  sbm_pkg::sbm_tag_t  tag2;
  logic               lin_zero2;
  logic               lin_sat2;
  logic [45:0]        qp2;
  logic [31:0]        rp2;

  // ------------------------------------------ stage 3: input level, red scale
  logic [15:0]        lin_c;
  logic [15:0]        red_c;
  logic [12:0]        red_val;
  logic [28:0]        xr_full;

  logic               v3;
  sbm_pkg::sbm_tag_t  tag3;
  logic [15:0]        lin3;
  logic               red_sat3;
  logic [17:0]        xr3;

  always_comb begin
    if (lin_zero2) begin
      lin_c = '0;
    end else if (lin_sat2) begin
      lin_c = 16'hFFFF;
    end else begin
      lin_c = qp2[sbm_pkg::IN_MUL_SHIFT+15:sbm_pkg::IN_MUL_SHIFT];
    end
    red_c   = rp2[31:16];
    red_val = red_c[12:0];
    xr_full = {red_val, 16'h0000} - {16'h0000, red_val};  // red * 65535
  end

  // ------------------------------------------ stage 4: reduction divide
  logic               v4;
  sbm_pkg::sbm_tag_t  tag4;
  logic [15:0]        lin4;
  logic               red_sat4;
  logic [36:0]        rq4;

  // ------------------------------- stage 5: band maxima, held store read
  logic [15:0]        lred_c;
  logic [15:0]        acc_in;
  logic [15:0]        acc_red;
  logic [15:0]        max_in_c;
  logic [15:0]        max_red_c;

  logic               v5;
  logic [sbm_pkg::BAND_W-1:0] band5;
  logic               last5;
  logic [15:0]        max_in5;
  logic [15:0]        max_red5;
  logic [31:0]        held_rd;
  logic               held_hit;

  logic [31:0]              held_mem [0:DISPLAY_BINS-1];
  logic [DISPLAY_BINS-1:0]  held_vld;
  logic [BAND_AW-1:0]       rd_addr;
  logic [BAND_AW-1:0]       wr_addr;

  always_comb begin
    lred_c    = red_sat4 ? 16'hFFFF : rq4[sbm_pkg::RED_MUL_SHIFT+15:sbm_pkg::RED_MUL_SHIFT];
    max_in_c  = (lin4 > acc_in) ? lin4 : acc_in;
    max_red_c = (lred_c > acc_red) ? lred_c : acc_red;
  end

  assign rd_addr = tag4.band[BAND_AW-1:0];
  assign wr_addr = band5[BAND_AW-1:0];

  // ------------------------------------------ stage 6: release and store
  logic [15:0] prev_in;
  logic [15:0] prev_red;
  logic        res_valid;
  result_t     res;

  always_comb begin
    prev_in       = held_hit ? held_rd[31:16] : 16'h0000;
    prev_red      = held_hit ? held_rd[15:0]  : 16'h0000;
    res.band      = band5;
    res.in_level  = release_level(prev_in, max_in5);
    res.red_level = release_level(prev_red, max_red5);
    res.last      = last5;
  end

  assign res_valid = v5 && en;

  // control state of the scaling stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      v5      <= 1'b0;
      acc_in  <= '0;
      acc_red <= '0;
    end else if (en) begin
      v1 <= log_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4 && tag4.close;
      if (v4) begin
        if (tag4.close) begin
          acc_in  <= '0;
          acc_red <= '0;
        end else begin
          acc_in  <= max_in_c;
          acc_red <= max_red_c;
        end
      end
    end
  end

  // payload of the scaling stages
  always_ff @(posedge clk) begin
    if (en) begin
      tag1      <= log_tag;
      x1        <= x_in_full[30:sbm_pkg::IN_PRE_SHIFT];
      lin_zero1 <= (t_in <= 18'sd0);
      lin_sat1  <= (t_in >= 18'(sbm_pkg::RANGE_IN_Q8));
      over1     <= (over_s < 17'sd0) ? 16'h0000 : over_s[15:0];

      tag2      <= tag1;
      lin_zero2 <= lin_zero1;
      lin_sat2  <= lin_sat1;
      qp2       <= 46'(x1) * 46'(sbm_pkg::IN_MUL);
      rp2       <= 32'(over1) * 32'(slope);

      tag3      <= tag2;
      lin3      <= lin_c;
      red_sat3  <= (red_c >= 16'(sbm_pkg::RANGE_RED_Q8));
      xr3       <= xr_full[28:sbm_pkg::RED_PRE_SHIFT];

      tag4      <= tag3;
      lin4      <= lin3;
      red_sat4  <= red_sat3;
      rq4       <= 37'(xr3) * 37'(sbm_pkg::RED_MUL);

      band5     <= tag4.band;
      last5     <= tag4.last;
      max_in5   <= max_in_c;
      max_red5  <= max_red_c;
    end
  end

  // held store, read when a band closes, written one stage later
  always_ff @(posedge clk) begin
    if (en && v4 && tag4.close) begin
      held_rd <= held_mem[rd_addr];
    end
    if (res_valid) begin
      held_mem[wr_addr] <= {res.in_level, res.red_level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_vld <= '0;
      held_hit <= 1'b0;
    end else begin
      if (en && v4 && tag4.close) begin
        held_hit <= held_vld[rd_addr];
      end
      if (res_valid) begin
        held_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------- output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (!out_valid) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && m_tready) begin
      if (skid_valid) begin
        out_res <= skid;
      end else if (res_valid) begin
        out_res <= res;
      end
    end else if (!out_valid) begin
      if (res_valid) begin
        out_res <= res;
      end
    end else if (res_valid) begin
      skid <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.red_level, out_res.in_level, out_res.band};
  assign m_tlast  = out_res.last;

endmodule

>>> tb/tb.sv
// self-checking testbench for the spectral band meter with peak hold and release
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DISPLAY_BINS   = 256;
  localparam int HALF_BINS      = 512;
  // beat that closes a band to its report, plus a margin for bins still in flight
  localparam int SETTLE_CYCLES  = 26 + 8;
  // long receiver hold-off, well past the pipeline depth plus both output slots
  localparam int RX_HOLD_CYCLES = 400;
  // cycles with no beat on any port before the run is abandoned
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RELEASE_KEEP   = 65536 - sbm_pkg::RELEASE_STEP;

  typedef struct {
    logic [7:0]  band;
    logic [15:0] input_level;
    logic [15:0] reduction_level;
    logic        last;
  } band_report_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [31:0]                   s_tdata;   // magnitude[31:0]
  logic                          m_tvalid;
  logic                          m_tready;
  logic [39:0]                   m_tdata;   // band_index[7:0], input_level[23:8],
                                            // reduction_level[39:24]
  logic                          m_tlast;   // frame_last
  logic                          cfg_we;
  logic [sbm_pkg::REG_IDX_W-1:0] cfg_index;
  logic [sbm_pkg::CFG_W-1:0]     cfg_data;

  // reports still owed by the block, oldest first
  band_report_t expected_reports[$];
  int           failures;

  // idling percentages, written only by the main sequence
  int tx_idle_pct;
  int rx_idle_pct;
  // bumped by the main sequence to ask the receiver for one long hold-off
  int rx_hold_requests;

  // own copy of the meter state and its registers
  int          threshold_q8;
  int          slope_q16;
  logic [15:0] held_input[DISPLAY_BINS];
  logic [15:0] held_reduction[DISPLAY_BINS];
  logic [15:0] band_peak_input;
  logic [15:0] band_peak_reduction;
  int          bin_count;
  int          band_count;

  spectral_band_meter_peak_release_top #(
    .DISPLAY_BINS(DISPLAY_BINS),
    .HALF_BINS   (HALF_BINS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  // log2 in q16 by repeated squaring of the q30 mantissa, then scaled to db q7.8
  function automatic int bin_to_db_q8(logic [31:0] mag);
    int          msb;
    int          i;
    logic [63:0] mant;
    logic [15:0] frac;
    longint      log2_q16;
    if (mag == 32'd0) begin
      return sbm_pkg::FLOOR_DB_Q8;   // silent bin floors at -120 db
    end
    msb = 31;
    while (!mag[msb]) msb--;
    mant = (msb <= 30) ? (64'(mag) << (30 - msb)) : (64'(mag) >> 1);
    frac = '0;
    for (i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 30;
      if (mant >= 64'h8000_0000) begin
        mant = mant >> 1;
        frac[15-i] = 1'b1;
      end
    end
    log2_q16 = longint'(msb - 16) * 65536 + longint'(frac);
    // arithmetic shift of a signed value rounds towards minus infinity
    return int'((log2_q16 * sbm_pkg::DB_PER_LOG2_Q16) >>> 24);
  endfunction

  function automatic logic [15:0] db_to_input_level(int db_q8);
    longint t;
    t = longint'(db_q8) + sbm_pkg::RANGE_IN_Q8;
    if (t <= 0) return 16'd0;
    if (t >= sbm_pkg::RANGE_IN_Q8) return 16'hFFFF;
    return 16'((t * 65535) / sbm_pkg::RANGE_IN_Q8);
  endfunction

  function automatic logic [15:0] db_to_reduction_level(int db_q8);
    longint over;
    longint red;
    over = longint'(db_q8) - threshold_q8;
    if (over < 0) over = 0;
    red = (over * slope_q16) >>> 16;
    if (red >= sbm_pkg::RANGE_RED_Q8) return 16'hFFFF;
    return 16'((red * 65535) / sbm_pkg::RANGE_RED_Q8);
  endfunction

  // instant rise, otherwise a rounded 0.88 decay towards the new peak
  function automatic logic [15:0] peak_release(logic [15:0] held, logic [15:0] peak);
    longint mix;
    if (peak > held) return peak;
    mix = (longint'(held) * RELEASE_KEEP + longint'(peak) * sbm_pkg::RELEASE_STEP + 32768)
          >>> 16;
    return (mix > 65535) ? 16'hFFFF : 16'(mix);
  endfunction

  function automatic void reset_meter_model();
    threshold_q8 = sbm_pkg::THRESHOLD_RESET;
    slope_q16    = sbm_pkg::SLOPE_RESET;
    foreach (held_input[b]) begin
      held_input[b]     = '0;
      held_reduction[b] = '0;
    end
    band_peak_input     = '0;
    band_peak_reduction = '0;
    bin_count           = 0;
    band_count          = 0;
  endfunction

  function automatic void apply_register(logic [sbm_pkg::REG_IDX_W-1:0] idx,
                                         logic [sbm_pkg::CFG_W-1:0] value);
    int ratio;
    case (idx)
      sbm_pkg::REG_THRESHOLD: begin
        threshold_q8 = int'($signed(value));
      end
      sbm_pkg::REG_RATIO: begin
        // the register keeps 14 bits, anything under 1.0 counts as 1.0
        ratio = int'(value[sbm_pkg::RATIO_W-1:0]);
        if (ratio < sbm_pkg::RATIO_MIN) ratio = sbm_pkg::RATIO_MIN;
        slope_q16 = 65536 - (2 ** 24) / ratio;
      end
      default: ;
    endcase
  endfunction

  // one accepted bin: update the band peaks, and on the closing bin owe a report
  function automatic void accept_bin(logic [31:0] mag);
    int           db_q8;
    logic [15:0]  in_lvl;
    logic [15:0]  red_lvl;
    int           band_end;
    band_report_t rep;
    db_q8   = bin_to_db_q8(mag);
    in_lvl  = db_to_input_level(db_q8);
    red_lvl = db_to_reduction_level(db_q8);
    if (in_lvl > band_peak_input) band_peak_input = in_lvl;
    if (red_lvl > band_peak_reduction) band_peak_reduction = red_lvl;
    band_end = ((band_count + 1) * (HALF_BINS + 1)) / DISPLAY_BINS;
    if (bin_count + 1 < band_end) begin
      bin_count++;
      return;
    end
    held_input[band_count]     = peak_release(held_input[band_count], band_peak_input);
    held_reduction[band_count] = peak_release(held_reduction[band_count], band_peak_reduction);
    rep.band            = 8'(band_count);
    rep.input_level     = held_input[band_count];
    rep.reduction_level = held_reduction[band_count];
    rep.last            = (band_count + 1 >= DISPLAY_BINS);
    expected_reports.insert(expected_reports.size(), rep);
    band_peak_input     = '0;
    band_peak_reduction = '0;
    if (rep.last) begin
      // frame done, next bin is bin 0 of band 0
      band_count = 0;
      bin_count  = 0;
    end else begin
      band_count++;
      bin_count++;
    end
  endfunction

  // ---------------------------------------------------------------- driving

  // offer one bin, with a random idle gap first, and wait for its beat
  task automatic send_bin(logic [31:0] mag);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= mag;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    accept_bin(mag);
  endtask

  task automatic end_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // wait for every owed report, then let bins that close no band drain out
  task automatic settle_pipeline();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [sbm_pkg::REG_IDX_W-1:0] idx,
                                logic [sbm_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // log-spread magnitudes so that every octave turns up, with both rails now and then
  function automatic logic [31:0] random_magnitude();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver

  // ready changes at the falling edge; a hold request keeps it low for a long stretch
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != rx_hold_requests) begin
        holds_seen = rx_hold_requests;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : report_check
    band_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, got band %0d", $time, m_tdata[7:0]);
        failures++;
      end else begin
        want = expected_reports.pop_front();
        check_field("band_index", want.band, m_tdata[7:0]);
        check_field("input_level", want.input_level, m_tdata[23:8]);
        check_field("reduction_level", want.reduction_level, m_tdata[39:24]);
        check_field("frame_last", want.last, m_tlast);
      end
    end
  end

  // stall watchdog: any beat on any port restarts the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles, %0d reports outstanding",
             WATCHDOG_LIMIT, expected_reports.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // rails of the magnitude: silence, lsb, full scale, unity and the msb alone
  task automatic test_magnitude_extremes();
    logic [31:0] mags[10];
    mags = '{32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000,
             32'h0000_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100, 32'h0012_3456};
    foreach (mags[i]) send_bin(mags[i]);
    end_stream();
  endtask

  // ratio at zero, just under 1.0, at 1.0, at 32.0 and all bits set
  task automatic test_ratio_edges();
    logic [sbm_pkg::CFG_W-1:0] ratios[5];
    ratios = '{16'd0, 16'd255, 16'd256, 16'd8192, 16'hFFFF};
    foreach (ratios[i]) begin
      settle_pipeline();
      write_register(sbm_pkg::REG_RATIO, ratios[i]);
      send_bin(32'hFFFF_FFFF);
      send_bin(32'h0040_0000);
      end_stream();
    end
  endtask

  // threshold below the silence floor gives silent bins a reduction, then the top
  task automatic test_threshold_edges();
    settle_pipeline();
    write_register(sbm_pkg::REG_RATIO, 16'(sbm_pkg::RATIO_RESET));
    write_register(sbm_pkg::REG_THRESHOLD, 16'h8000);
    send_bin(32'd0);
    send_bin(32'd1);
    end_stream();
    settle_pipeline();
    write_register(sbm_pkg::REG_THRESHOLD, 16'h7FFF);
    send_bin(32'hFFFF_FFFF);
    send_bin(32'hFFFF_0000);
    end_stream();
  endtask

  // random bins across band and frame boundaries under one register setting
  task automatic test_random_traffic(int tx_pct, int rx_pct,
                                     logic [sbm_pkg::CFG_W-1:0] threshold,
                                     logic [sbm_pkg::CFG_W-1:0] ratio, int count);
    settle_pipeline();
    write_register(sbm_pkg::REG_THRESHOLD, threshold);
    write_register(sbm_pkg::REG_RATIO, ratio);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_bin(random_magnitude());
    end_stream();
  endtask

  // receiver holds off while bins keep coming, so the block fills and stops taking input
  task automatic test_output_backpressure();
    settle_pipeline();
    write_register(sbm_pkg::REG_THRESHOLD, 16'(sbm_pkg::THRESHOLD_RESET));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_requests++;
    repeat (64) send_bin(random_magnitude());
    end_stream();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    failures         = 0;
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    rx_hold_requests = 0;
    reset_meter_model();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= sbm_pkg::REG_THRESHOLD;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_magnitude_extremes();
    test_ratio_edges();
    test_threshold_edges();
    // receiver mostly stalled, then the sender mostly idle, then flat out
    test_random_traffic(37, 79, 16'(-30720), 16'd8192, 300);
    test_random_traffic(79, 37, 16'd12288, 16'd256, 300);
    test_random_traffic(0, 0, 16'(int'($urandom_range(43008)) - 30720),
                        16'($urandom_range(256, 8192)), 300);
    test_output_backpressure();

    // drain, then a latency's worth of quiet to catch stray beats
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
design/sbm_pkg.sv
design/sbm_slope_div.sv
design/sbm_log_pipe.sv
design/spectral_band_meter_peak_release_top.sv
tb/tb.sv
